@@ design/dense_relu_layer_trainer_unit_assert.svh @@
`ifndef DENSE_RELU_LAYER_TRAINER_UNIT_ASSERT_SVH
`define DENSE_RELU_LAYER_TRAINER_UNIT_ASSERT_SVH
// clocked implication with reset disable
`define DRLT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// clocked next-cycle implication
`define DRLT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ design/drlt_pkg.sv @@
package drlt_pkg;
	localparam int DefInNeurons  = 16;
	localparam int DefOutNeurons = 16;
	localparam int DefDataWidth  = 16;
	localparam int AccW          = 40;

	localparam logic [1:0] REG_LR = 2'd0;
	localparam logic [1:0] REG_IC = 2'd1;
	localparam logic [1:0] REG_NC = 2'd2;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_FWD   = 2'd1,
		MODE_BACK  = 2'd2,
		MODE_UPD   = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_FWD_RD,
		ST_FWD_MAC,
		ST_FWD_OUT,
		ST_BK_DLT,
		ST_BK_RD,
		ST_BK_MUL,
		ST_BK_WR,
		ST_BK_OUT,
		ST_UP_RD,
		ST_UP_MUL,
		ST_UP_WR
	} state_t;

	// shared multiplier operation
	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
	} mul_op_t;

	function automatic logic signed [AccW-1:0] round8(input logic signed [AccW-1:0] x);
		logic signed [AccW:0] t;
		t = (AccW+1)'(x) + (AccW+1)'(128);
		return AccW'(t >>> 8);
	endfunction
endpackage

@@ design/drlt_mul.sv @@
module drlt_mul
	import drlt_pkg::*;
(
	input  logic                clk,
	input  drlt_pkg::mul_op_t   op,
	output logic signed [63:0]  prod_s1
);
	always_ff @(posedge clk) begin
		prod_s1 <= op.a * op.b;
	end
endmodule

@@ design/drlt_ram.sv @@
module drlt_ram
	import drlt_pkg::*;
#(
	parameter int Depth = 256,
	parameter int Width = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata_q
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end
endmodule

@@ design/dense_relu_layer_trainer_unit.sv @@
// Dense ReLU layer trainer. Commands enter on start while busy is low and the
// block then holds busy for the whole command; results leave as one-cycle
// strobes on valid and cannot be stalled. A last forward beat runs every
// neuron in use over every input in use, a last backprop beat does the same
// to write gradients, and an update passes over every weight in use. One
// shared multiplier does all the products, with one weight memory and one
// gradient memory. Gradients are cleared after reset by a pass that writes
// zero to each of the OUT_NEURONS*IN_NEURONS entries, during which busy
// stays high.
module dense_relu_layer_trainer_unit
	import drlt_pkg::*;
#(
	parameter int IN_NEURONS  = DefInNeurons,
	parameter int OUT_NEURONS = DefOutNeurons,
	parameter int DATA_WIDTH  = DefDataWidth
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [3:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [5:0]                   row,
	input  logic [5:0]                   col,
	input  logic signed [DATA_WIDTH-1:0] value,
	input  logic signed [DATA_WIDTH-1:0] delta_in,
	input  logic                         last,
	output logic                         valid,
	output logic [5:0]                   index,
	output logic signed [DATA_WIDTH-1:0] result,
	output logic                         is_delta,
	output logic                         last_result
);
	localparam int IW = (IN_NEURONS > 1) ? $clog2(IN_NEURONS) : 1;
	localparam int OW = (OUT_NEURONS > 1) ? $clog2(OUT_NEURONS) : 1;
	localparam int MD = OUT_NEURONS * IN_NEURONS;
	localparam int MW = (MD > 1) ? $clog2(MD) : 1;
	localparam logic signed [AccW-1:0] DHi = AccW'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
	localparam logic signed [AccW-1:0] DLo = -DHi - AccW'(1);

	function automatic logic signed [DATA_WIDTH-1:0] satd(input logic signed [AccW-1:0] x);
		if (x > DHi) return DHi[DATA_WIDTH-1:0];
		if (x < DLo) return DLo[DATA_WIDTH-1:0];
		return x[DATA_WIDTH-1:0];
	endfunction

	logic [15:0] lr_q;
	logic [6:0]  ic_q, nc_q;
	logic [IW:0] m_use;
	logic [OW:0] n_use;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= 16'd655;
			ic_q <= 7'd16;
			nc_q <= 7'd16;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_LR:  lr_q <= pwdata[15:0];
				REG_IC:  ic_q <= pwdata[6:0];
				REG_NC:  nc_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[3:2])
			REG_LR:  prdata = {16'd0, lr_q};
			REG_IC:  prdata = {25'd0, ic_q};
			REG_NC:  prdata = {25'd0, nc_q};
			default: prdata = 32'd0;
		endcase
	end
	always_comb begin
		if (ic_q == 7'd0) m_use = (IW+1)'(1);
		else if (32'(ic_q) > IN_NEURONS) m_use = (IW+1)'(IN_NEURONS);
		else m_use = (IW+1)'(ic_q);
		if (nc_q == 7'd0) n_use = (OW+1)'(1);
		else if (32'(nc_q) > OUT_NEURONS) n_use = (OW+1)'(OUT_NEURONS);
		else n_use = (OW+1)'(nc_q);
	end

	// small per-neuron stores in flip-flops with reset
	logic signed [DATA_WIDTH-1:0] act_q [IN_NEURONS];
	logic signed [DATA_WIDTH-1:0] pre_q [OUT_NEURONS];
	logic signed [AccW-1:0]       dsum_q [OUT_NEURONS];

	state_t st_q, st_d;
	logic [1:0] md_q;
	logic [5:0] row_q, col_q;
	logic signed [DATA_WIDTH-1:0] val_q, dlt_q;
	logic last_q;
	logic [OW:0] j_q;
	logic [IW:0] i_q;
	logic [MW:0] clr_q;
	logic signed [AccW-1:0] acc_q;
	logic signed [DATA_WIDTH-1:0] d_q;

	logic w_we, g_we;
	logic [MW-1:0] w_wa, g_wa, w_ra, g_ra;
	logic [DATA_WIDTH-1:0] w_wd, g_wd, w_rd, g_rd;

	drlt_ram #(.Depth(MD), .Width(DATA_WIDTH)) u_wram (
		.clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata_q(w_rd)
	);
	drlt_ram #(.Depth(MD), .Width(DATA_WIDTH)) u_gram (
		.clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata_q(g_rd)
	);

	mul_op_t mop;
	logic signed [63:0] prod_s1;
	drlt_mul u_mul (.clk(clk), .op(mop), .prod_s1(prod_s1));

	logic [MW-1:0] ji_addr;
	assign ji_addr = MW'(32'(j_q[OW-1:0]) * IN_NEURONS + 32'(i_q[IW-1:0]));

	logic i_end, j_end;
	assign i_end = (i_q + (IW+1)'(1)) == m_use;
	assign j_end = (j_q + (OW+1)'(1)) == n_use;

	logic signed [AccW-1:0] stepv, neww;
	always_comb begin
		stepv = AccW'(satd(AccW'((prod_s1 + 64'sd32768) >>> 16)));
		neww  = AccW'($signed(w_rd)) - stepv;
	end

	always_comb begin
		st_d = st_q;
		mop.a = '0;
		mop.b = '0;
		w_we = 1'b0; w_wa = ji_addr; w_wd = val_q; w_ra = ji_addr;
		g_we = 1'b0; g_wa = ji_addr; g_wd = '0; g_ra = ji_addr;
		case (st_q)
			ST_IDLE: begin
				if (clr_q != (MW+1)'(MD)) begin
					g_we = 1'b1;
					g_wa = clr_q[MW-1:0];
				end else if (start) begin
					st_d = ST_ACC;
				end
			end
			ST_ACC: begin
				mop.a = 32'(val_q);
				mop.b = 32'(dlt_q);
				if (md_q == MODE_WRITE) begin
					w_we = (32'(row_q) < OUT_NEURONS) && (32'(col_q) < IN_NEURONS);
					w_wa = MW'(32'(row_q) * IN_NEURONS + 32'(col_q));
					st_d = ST_IDLE;
				end else if (md_q == MODE_FWD) begin
					st_d = last_q ? ST_FWD_RD : ST_IDLE;
				end else if (md_q == MODE_BACK) begin
					st_d = ST_BK_DLT;
				end else begin
					st_d = ST_UP_RD;
				end
			end
			ST_FWD_RD: st_d = ST_FWD_MAC;
			ST_FWD_MAC: begin
				mop.a = 32'($signed(w_rd));
				mop.b = 32'(act_q[i_q[IW-1:0]]);
				st_d = i_end ? ST_FWD_OUT : ST_FWD_RD;
			end
			ST_FWD_OUT: st_d = j_end ? ST_IDLE : ST_FWD_RD;
			ST_BK_DLT: st_d = last_q ? ST_BK_RD : ST_IDLE;
			ST_BK_RD: st_d = ST_BK_MUL;
			ST_BK_MUL: begin
				mop.a = 32'(d_q);
				mop.b = 32'(act_q[i_q[IW-1:0]]);
				st_d = ST_BK_WR;
			end
			ST_BK_WR: begin
				g_we = 1'b1;
				g_wd = satd(round8(AccW'(prod_s1)));
				st_d = i_end ? ST_BK_OUT : ST_BK_RD;
			end
			ST_BK_OUT: st_d = j_end ? ST_IDLE : ST_BK_RD;
			ST_UP_RD: st_d = ST_UP_MUL;
			ST_UP_MUL: begin
				mop.a = 32'({1'b0, lr_q});
				mop.b = 32'($signed(g_rd));
				st_d = ST_UP_WR;
			end
			ST_UP_WR: begin
				w_we = 1'b1;
				w_wd = satd(neww);
				st_d = (i_end && j_end) ? ST_IDLE : ST_UP_RD;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign busy = (st_q != ST_IDLE) || (clr_q != (MW+1)'(MD));

	logic signed [AccW-1:0] dsum_new;
	logic signed [AccW:0] dsum_wide;
	always_comb begin
		dsum_wide = (AccW+1)'(dsum_q[col_q[OW-1:0]]) + (AccW+1)'(prod_s1);
		if (dsum_wide > (AccW+1)'(((65'sd1) <<< (AccW-1)) - 1))
			dsum_new = {1'b0, {(AccW-1){1'b1}}};
		else if (dsum_wide < -((AccW+1)'(65'sd1 <<< (AccW-1))))
			dsum_new = {1'b1, {(AccW-1){1'b0}}};
		else dsum_new = dsum_wide[AccW-1:0];
	end

	// last product of a row folds in at the output step
	logic signed [DATA_WIDTH-1:0] zr;
	assign zr = satd(round8(acc_q + AccW'(prod_s1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			valid <= 1'b0;
			for (int k = 0; k < IN_NEURONS; k++) act_q[k] <= '0;
			for (int k = 0; k < OUT_NEURONS; k++) begin
				pre_q[k] <= '0;
				dsum_q[k] <= '0;
			end
			j_q <= '0;
			i_q <= '0;
		end else begin
			valid <= 1'b0;
			if (st_q == ST_IDLE && clr_q != (MW+1)'(MD)) clr_q <= clr_q + (MW+1)'(1);
			case (st_q)
				ST_ACC: begin
					j_q <= '0;
					i_q <= '0;
					if (md_q == MODE_FWD && 32'(col_q) < IN_NEURONS)
						act_q[col_q[IW-1:0]] <= val_q;
				end
				ST_BK_DLT: begin
					if (32'(col_q) < OUT_NEURONS)
						dsum_q[col_q[OW-1:0]] <= dsum_new;
				end
				ST_FWD_MAC: begin
					i_q <= i_end ? '0 : i_q + (IW+1)'(1);
				end
				ST_FWD_OUT: begin
					pre_q[j_q[OW-1:0]] <= zr;
					valid <= 1'b1;
					j_q <= j_q + (OW+1)'(1);
				end
				ST_BK_WR: i_q <= i_end ? '0 : i_q + (IW+1)'(1);
				ST_BK_OUT: begin
					valid <= 1'b1;
					j_q <= j_q + (OW+1)'(1);
					if (j_end)
						for (int k = 0; k < OUT_NEURONS; k++) dsum_q[k] <= '0;
				end
				ST_UP_WR: begin
					i_q <= i_end ? '0 : i_q + (IW+1)'(1);
					if (i_end) j_q <= j_q + (OW+1)'(1);
				end
				default: ;
			endcase
		end
	end

	// gating by preactivation for the current neuron's delta
	logic signed [DATA_WIDTH-1:0] dj;
	assign dj = (pre_q[j_q[OW-1:0]] > 0) ?
		satd(round8(dsum_q[j_q[OW-1:0]])) : '0;

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			md_q <= mode;
			row_q <= row;
			col_q <= col;
			val_q <= value;
			dlt_q <= delta_in;
			last_q <= last;
		end
		if (st_q == ST_FWD_RD) acc_q <= (i_q == '0) ? '0 : acc_q + AccW'(prod_s1);
		if (st_q == ST_BK_RD && i_q == '0) d_q <= dj;
		if (st_q == ST_FWD_OUT) begin
			index <= 6'(j_q);
			result <= (zr > 0) ? zr : '0;
			is_delta <= 1'b0;
			last_result <= j_end;
		end
		if (st_q == ST_BK_OUT) begin
			index <= 6'(j_q);
			result <= d_q;
			is_delta <= 1'b1;
			last_result <= j_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end
endmodule

@@ design/drlt_checker.sv @@
`include "dense_relu_layer_trainer_unit_assert.svh"
module drlt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic valid,
	input logic last_result,
	input logic pready
);
	`DRLT_ASSERT_IMP(a_rdy, clk, arst_n, 1'b1, pready)
	`DRLT_ASSERT_IMP(a_vbusy, clk, arst_n, valid && !last_result, busy)
	`DRLT_ASSERT_NXT(a_take, clk, arst_n, start && !busy, busy)
endmodule

bind dense_relu_layer_trainer_unit drlt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.valid(valid), .last_result(last_result), .pready(pready)
);
